/* hdl/hne_pkg.sv */
// hne_pkg: types and constants shared by the html numeric entity encoder
// no dependencies
package hne_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned MAX_LEN = 6;
   localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
   localparam int unsigned POS_W   = $clog2(MAX_LEN);

   localparam logic [BYTE_W-1:0] CHAR_AMP   = 8'h26;
   localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3b;
   localparam logic [BYTE_W-1:0] CHAR_LT    = 8'h3c;
   localparam logic [BYTE_W-1:0] CHAR_GT    = 8'h3e;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

   typedef struct packed {
      logic [MAX_LEN-1:0][BYTE_W-1:0] bytes;
      logic [LEN_W-1:0]               len;
      logic                           inside_tag_next;
   } hne_seq_type;

endpackage

/* hdl/hne_if.sv */
// hne_req_if / hne_rsp_if: valid-ready channels of the encoder
// depends on hne_pkg
interface hne_req_if;
   logic                          valid;
   logic                          ready;
   logic [hne_pkg::BYTE_W-1:0]    text_byte;
   logic                          text_start;

   modport source (output valid, output text_byte, output text_start, input ready);
   modport sink   (input valid, input text_byte, input text_start, output ready);
endinterface

interface hne_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hne_pkg::BYTE_W-1:0]    out_byte;
   logic                          last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* hdl/hne_format.sv */
// hne_format: builds the output byte sequence and next tag state for one item
// depends on hne_pkg
module hne_format (
   input  logic [hne_pkg::BYTE_W-1:0] text_byte,
   input  logic                       text_start,
   input  logic                       encode_all,
   input  logic                       inside_tag,
   output hne_pkg::hne_seq_type       seq
);

   logic [6:0]  rem;
   logic [1:0]  hundreds;
   logic [14:0] prod;
   logic [3:0]  tens;
   logic [6:0]  tens_x10;
   logic [3:0]  ones;
   logic [hne_pkg::BYTE_W-1:0] h_char;
   logic [hne_pkg::BYTE_W-1:0] t_char;
   logic [hne_pkg::BYTE_W-1:0] o_char;
   logic        tag_cur;
   logic        do_encode;

   always_comb begin
      if (text_byte >= 8'd200) begin
         hundreds = 2'd2;
         rem      = 7'(text_byte - 8'd200);
      end else if (text_byte >= 8'd100) begin
         hundreds = 2'd1;
         rem      = 7'(text_byte - 8'd100);
      end else begin
         hundreds = 2'd0;
         rem      = text_byte[6:0];
      end
      // divide by ten through reciprocal, exact below 100
      prod     = 15'(rem) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = 7'(tens) * 7'd10;
      ones     = 4'(rem - tens_x10);
      h_char   = hne_pkg::CHAR_ZERO | {6'd0, hundreds};
      t_char   = hne_pkg::CHAR_ZERO | {4'd0, tens};
      o_char   = hne_pkg::CHAR_ZERO | {4'd0, ones};
   end

   always_comb begin
      tag_cur             = inside_tag & ~text_start;
      seq.inside_tag_next = tag_cur;
      do_encode           = 1'b0;
      if (encode_all) begin
         do_encode = 1'b1;
      end else if (text_byte inside {hne_pkg::CHAR_CR, hne_pkg::CHAR_LF, hne_pkg::CHAR_TAB}) begin
         do_encode = 1'b0;
      end else if (text_byte == hne_pkg::CHAR_LT) begin
         seq.inside_tag_next = 1'b1;
      end else if (text_byte == hne_pkg::CHAR_GT) begin
         seq.inside_tag_next = 1'b0;
      end else if (!tag_cur) begin
         do_encode = 1'b1;
      end

      seq.bytes = '0;
      if (!do_encode) begin
         seq.bytes[0] = text_byte;
         seq.len      = hne_pkg::LEN_W'(1);
      end else begin
         seq.bytes[0] = hne_pkg::CHAR_AMP;
         seq.bytes[1] = hne_pkg::CHAR_HASH;
         if (hundreds != 2'd0) begin
            seq.bytes[2] = h_char;
            seq.bytes[3] = t_char;
            seq.bytes[4] = o_char;
            seq.bytes[5] = hne_pkg::CHAR_SEMI;
            seq.len      = hne_pkg::LEN_W'(6);
         end else if (tens != 4'd0) begin
            seq.bytes[2] = t_char;
            seq.bytes[3] = o_char;
            seq.bytes[4] = hne_pkg::CHAR_SEMI;
            seq.len      = hne_pkg::LEN_W'(5);
         end else begin
            seq.bytes[2] = o_char;
            seq.bytes[3] = hne_pkg::CHAR_SEMI;
            seq.len      = hne_pkg::LEN_W'(4);
         end
      end
   end

endmodule

/* hdl/html_numeric_entity_encoder_unit.sv */
// html_numeric_entity_encoder_unit: top level of the html numeric entity encoder
// depends on hne_pkg, hne_req_if, hne_rsp_if and hne_format
// Each text byte on req is answered on rsp either by itself (one byte) or by
// its reference "&#<decimal>;" (four to six bytes), with last_of_run on the
// final byte. Unless rsp.ready stalls it, the rsp side moves one byte per
// cycle and a raw stream runs at one item per cycle; the serializer holds an
// item for its one raw byte or four to six encoded bytes. A byte passes the
// input register, serializer and output register. encode_all is written
// through csr_write_enable while idle by the user, not enforced by the block.
module html_numeric_entity_encoder_unit (
   input  logic         clock,
   input  logic         reset,
   hne_req_if.sink      req,
   hne_rsp_if.source    rsp,
   input  logic         csr_write_enable,
   input  logic         csr_write_data
);

   logic                                  encode_all_ff, encode_all_in;
   logic                                  inside_tag_ff, inside_tag_in;

   logic                                  in_valid_ff, in_valid_in;
   logic [hne_pkg::BYTE_W-1:0]            in_byte_ff, in_byte_in;
   logic                                  in_start_ff, in_start_in;

   logic                                  ser_valid_ff, ser_valid_in;
   logic [hne_pkg::MAX_LEN-1:0][hne_pkg::BYTE_W-1:0] ser_bytes_ff, ser_bytes_in;
   logic [hne_pkg::LEN_W-1:0]             ser_len_ff, ser_len_in;
   logic [hne_pkg::POS_W-1:0]             ser_pos_ff, ser_pos_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [hne_pkg::BYTE_W-1:0]            rsp_byte_ff, rsp_byte_in;
   logic                                  rsp_last_ff, rsp_last_in;

   hne_pkg::hne_seq_type                  seq;
   logic                                  out_load;
   logic                                  ser_at_last;
   logic                                  ser_load;
   logic                                  in_load;

   hne_format u_format (
      .text_byte  (in_byte_ff),
      .text_start (in_start_ff),
      .encode_all (encode_all_ff),
      .inside_tag (inside_tag_ff),
      .seq        (seq)
   );

   assign ser_at_last = (hne_pkg::LEN_W'(ser_pos_ff) == ser_len_ff - hne_pkg::LEN_W'(1));
   assign out_load    = ser_valid_ff & (~rsp_valid_ff | rsp.ready);
   assign ser_load    = in_valid_ff & (~ser_valid_ff | (out_load & ser_at_last));
   assign in_load     = req.valid & req.ready;

   assign req.ready       = ~in_valid_ff | ser_load;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = rsp_byte_ff;
   assign rsp.last_of_run = rsp_last_ff;

   always_comb begin
      encode_all_in = csr_write_enable ? csr_write_data : encode_all_ff;
      inside_tag_in = ser_load ? seq.inside_tag_next : inside_tag_ff;

      in_valid_in = in_load | (in_valid_ff & ~ser_load);
      in_byte_in  = in_load ? req.text_byte : in_byte_ff;
      in_start_in = in_load ? req.text_start : in_start_ff;

      ser_valid_in = ser_valid_ff;
      ser_bytes_in = ser_bytes_ff;
      ser_len_in   = ser_len_ff;
      ser_pos_in   = ser_pos_ff;
      if (ser_load) begin
         ser_valid_in = 1'b1;
         ser_bytes_in = seq.bytes;
         ser_len_in   = seq.len;
         ser_pos_in   = '0;
      end else if (out_load) begin
         ser_valid_in = ~ser_at_last;
         ser_pos_in   = ser_pos_ff + hne_pkg::POS_W'(1);
      end

      rsp_valid_in = out_load | (rsp_valid_ff & ~rsp.ready);
      rsp_byte_in  = out_load ? ser_bytes_ff[ser_pos_ff] : rsp_byte_ff;
      rsp_last_in  = out_load ? ser_at_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         encode_all_ff <= 1'b0;
         inside_tag_ff <= 1'b0;
         in_valid_ff   <= 1'b0;
         ser_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         encode_all_ff <= encode_all_in;
         inside_tag_ff <= inside_tag_in;
         in_valid_ff   <= in_valid_in;
         ser_valid_ff  <= ser_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      in_start_ff  <= in_start_in;
      ser_bytes_ff <= ser_bytes_in;
      ser_len_ff   <= ser_len_in;
      ser_pos_ff   <= ser_pos_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

`ifndef ASSERT_OFF
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> (hne_pkg::LEN_W'(ser_pos_ff) < ser_len_ff))
      else $error("serializer position beyond sequence length");

   a_len_legal: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> (ser_len_ff == hne_pkg::LEN_W'(1) || ser_len_ff == hne_pkg::LEN_W'(4)
                        || ser_len_ff == hne_pkg::LEN_W'(5) || ser_len_ff == hne_pkg::LEN_W'(6)))
      else $error("illegal sequence length");

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      ser_load |=> (ser_valid_ff && ser_pos_ff == '0))
      else $error("serializer did not restart on load");

   a_mid_run_holds: assert property (@(posedge clock) disable iff (reset)
      (out_load && !ser_at_last) |=> (ser_valid_ff && ser_pos_ff == $past(ser_pos_ff) + 1'b1))
      else $error("item dropped in the middle of its run");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ser_valid_ff && !(out_load && ser_at_last)) |-> !ser_load)
      else $error("serializer overwritten while busy");
`endif

endmodule
